@@ hw/rtl/tte_pkg.sv @@
// Shared constants and widths for the tap tempo estimator.
// Used by tte_cell, tte_div, tap_tempo_estimator, tte_checker and testbench; no dependencies.
package tte_pkg;

  // Number of intervals kept in the history ring (1 to 15)
  localparam int HistoryDepth = 10;

  localparam int TimeW     = 32;
  localparam int IntervalW = 16;
  localparam int ThreshW   = 16;
  localparam int HalfW     = 15;
  localparam int SamplesW  = 4;

  // Ring slot index and fill count (fill count must hold HistoryDepth itself)
  localparam int SlotW = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int CntW  = $clog2(HistoryDepth + 1);

  // Sum of up to HistoryDepth intervals
  localparam int SumW    = IntervalW + CntW;
  localparam int DivCntW = $clog2(SumW + 1);

  localparam logic [ThreshW-1:0] GapThresholdReset = ThreshW'(5 * 1000);

  typedef logic [IntervalW-1:0] interval_t;

endpackage

@@ hw/rtl/tap_tempo_estimator.sv @@
// Tap tempo estimator: interval history ring of tte_cell, serial divider tte_div.
// Sequence: accept, a walk over every ring cell, divider load, serial divide, then
//   the output register once any earlier estimate has been taken; a restart tap
//   goes from accept straight to the output register.
// One tap in flight: a new tap is accepted only in idle, after the previous one
//   has reached the output register.
// Reset: control cleared, threshold 5000 ms; history cells are not reset.
module tap_tempo_estimator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tte_pkg::ThreshW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tte_pkg::TimeW-1:0]    tap_time_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         restarted_o,
  output logic [tte_pkg::IntervalW-1:0] average_interval_o,
  output logic [tte_pkg::HalfW-1:0]    half_spread_o,
  output logic [tte_pkg::SamplesW-1:0] samples_used_o
);
  import tte_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StWalk   = 3'd1;
  localparam logic [2:0] StDstart = 3'd2;
  localparam logic [2:0] StDiv    = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [ThreshW-1:0] thr_q;
  logic [TimeW-1:0]   last_q, last_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [SlotW-1:0]   step_q, step_d;
  logic               rst_flag_q, rst_flag_d;
  logic [SumW-1:0]    sum_q, sum_d;
  interval_t          lo_q, lo_d, hi_q, hi_d;

  logic               out_valid_q;
  logic               restarted_q;
  interval_t          avg_q;
  logic [HalfW-1:0]   half_q;
  logic [SamplesW-1:0] samples_q;

  logic               accept;
  logic [TimeW-1:0]   gap;
  logic               restart;
  logic               walking;
  logic               div_start;
  logic               div_done;
  logic [SumW-1:0]    div_quo;
  logic               emit;
  interval_t          head;
  interval_t          spread;
  interval_t          cell_val [HistoryDepth];

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign gap        = tap_time_ms_i - last_q;
  assign restart    = gap > {{(TimeW-ThreshW){1'b0}}, thr_q};
  assign walking    = (state_q == StWalk);
  assign div_start  = (state_q == StDstart);
  assign emit       = (state_q == StEmit) && (!out_valid_q || out_ready_i);
  assign head       = cell_val[0];
  assign spread     = hi_q - lo_q;

  // Ring of cells; during the walk each cell takes its upper neighbor's entry,
  // so entry i sits at the head on walk step i and the ring ends where it began.
  for (genvar k = 0; k < HistoryDepth; k++) begin : g_cell
    tte_cell u_cell (
      .clk_i        (clk_i),
      .load_i       (accept && !restart && (slot_q == SlotW'(k))),
      .load_data_i  (gap[IntervalW-1:0]),
      .shift_i      (walking),
      .shift_data_i (cell_val[(k + 1) % HistoryDepth]),
      .entry_o      (cell_val[k])
    );
  end

  tte_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    slot_d     = slot_q;
    fill_d     = fill_q;
    step_d     = step_q;
    rst_flag_d = rst_flag_q;
    sum_d      = sum_q;
    lo_d       = lo_q;
    hi_d       = hi_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          last_d     = tap_time_ms_i;
          rst_flag_d = restart;
          step_d     = '0;
          sum_d      = '0;
          lo_d       = '1;
          hi_d       = '0;
          if (restart) begin
            slot_d  = '0;
            fill_d  = '0;
            state_d = StEmit;
          end else begin
            slot_d  = (slot_q == SlotW'(HistoryDepth - 1)) ? '0 : slot_q + SlotW'(1);
            if (fill_q < CntW'(HistoryDepth)) begin
              fill_d = fill_q + CntW'(1);
            end
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (CntW'(step_q) < fill_q) begin
          sum_d = sum_q + SumW'(head);
          if (head < lo_q) lo_d = head;
          if (head > hi_q) hi_d = head;
        end
        step_d = step_q + SlotW'(1);
        if (step_q == SlotW'(HistoryDepth - 1)) begin
          state_d = StDstart;
        end
      end
      StDstart: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (emit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      thr_q       <= GapThresholdReset;
      last_q      <= '0;
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      slot_q  <= slot_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    rst_flag_q <= rst_flag_d;
    sum_q      <= sum_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    if (emit) begin
      restarted_q <= rst_flag_q;
      avg_q       <= rst_flag_q ? '0 : div_quo[IntervalW-1:0];
      half_q      <= rst_flag_q ? '0 : spread[IntervalW-1:1];
      samples_q   <= rst_flag_q ? '0 : fill_q[SamplesW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign restarted_o        = restarted_q;
  assign average_interval_o = avg_q;
  assign half_spread_o      = half_q;
  assign samples_used_o     = samples_q;

  // A restart tap empties the history
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart |=> (fill_q == '0) && (slot_q == '0))
    else $error("restart did not empty the history");

  // A stored tap always leaves at least one sample to average
  a_store_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !restart |=> (fill_q != '0) && (state_q == StWalk))
    else $error("stored tap left empty history");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(HistoryDepth))
    else $error("fill count beyond history depth");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv)
    else $error("divider result outside divide state");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && (state_q == StIdle))
    else $error("result not registered on emit");

endmodule

@@ hw/rtl/tte_cell.sv @@
// One history entry of the interval ring.
// Depends on tte_pkg; loads a new interval or takes its neighbor's value.
module tte_cell (
  input  logic                clk_i,
  input  logic                load_i,
  input  tte_pkg::interval_t  load_data_i,
  input  logic                shift_i,
  input  tte_pkg::interval_t  shift_data_i,
  output tte_pkg::interval_t  entry_o
);
  import tte_pkg::*;

  interval_t entry_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= load_data_i;
    end else if (shift_i) begin
      entry_q <= shift_data_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/tte_div.sv @@
// Serial restoring divider: one quotient bit per cycle.
// Depends on tte_pkg for the dividend and divisor widths.
module tte_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tte_pkg::SumW-1:0] dividend_i,
  input  logic [tte_pkg::CntW-1:0] divisor_i,
  output logic                     done_o,
  output logic [tte_pkg::SumW-1:0] quotient_o
);
  import tte_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]    quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]    dsr_q, dsr_d;
  logic [CntW:0]      rem_shift;
  logic [CntW:0]      rem_sub;
  logic               fits;

  always_comb begin
    rem_shift = {rem_q, quo_q[SumW-1]};
    fits      = rem_shift >= {1'b0, dsr_q};
    rem_sub   = rem_shift - {1'b0, dsr_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(SumW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops off
      rem_d = fits ? rem_sub[CntW-1:0] : rem_shift[CntW-1:0];
      quo_d = {quo_q[SumW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ verif/tte_checker.sv @@
// Scoreboard for tap_tempo_estimator: watches the config, tap and estimate channels,
// predicts each estimate from its own copy of the interval ring and compares.
// Depends on tte_pkg for widths and the history depth.
`timescale 1ns / 1ps

module tte_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tte_pkg::ThreshW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [tte_pkg::TimeW-1:0]     tap_time_ms_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          restarted_i,
  input  logic [tte_pkg::IntervalW-1:0] average_interval_i,
  input  logic [tte_pkg::HalfW-1:0]     half_spread_i,
  input  logic [tte_pkg::SamplesW-1:0]  samples_used_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            results_o,
  output int                            restarts_o,
  output int                            full_ring_o
);

  typedef struct packed {
    logic                          restarted;
    logic [tte_pkg::IntervalW-1:0] average;
    logic [tte_pkg::HalfW-1:0]     half_spread;
    logic [tte_pkg::SamplesW-1:0]  samples;
  } estimate_t;

  logic [tte_pkg::ThreshW-1:0]   gap_limit_ms;
  logic [tte_pkg::TimeW-1:0]     prev_tap_ms;
  logic [tte_pkg::IntervalW-1:0] interval_ring [tte_pkg::HistoryDepth];
  int                            ring_slot;
  int                            ring_fill;
  estimate_t                     estimate_q [$];
  estimate_t                     want;

  // Advances the ring copy by one tap and returns the estimate it should produce.
  function automatic estimate_t predict_estimate(input logic [tte_pkg::TimeW-1:0] now_ms);
    logic [tte_pkg::TimeW-1:0]     gap;
    logic [31:0]                   sum;
    logic [tte_pkg::IntervalW-1:0] lo;
    logic [tte_pkg::IntervalW-1:0] hi;
    logic [tte_pkg::IntervalW-1:0] spread;
    estimate_t                     est;
    gap = now_ms - prev_tap_ms;
    prev_tap_ms = now_ms;
    est = '0;
    if (gap > {16'b0, gap_limit_ms}) begin
      ring_slot = 0;
      ring_fill = 0;
      est.restarted = 1'b1;
    end else begin
      interval_ring[ring_slot] = gap[tte_pkg::IntervalW-1:0];
      ring_slot = (ring_slot + 1 >= tte_pkg::HistoryDepth) ? 0 : ring_slot + 1;
      if (ring_fill < tte_pkg::HistoryDepth) ring_fill++;
      sum = '0;
      lo = '1;
      hi = '0;
      for (int i = 0; i < ring_fill; i++) begin
        sum = sum + 32'(interval_ring[i]);
        if (interval_ring[i] < lo) lo = interval_ring[i];
        if (interval_ring[i] > hi) hi = interval_ring[i];
      end
      spread = hi - lo;
      est.average = tte_pkg::IntervalW'(sum / 32'(ring_fill));
      est.half_spread = tte_pkg::HalfW'(spread >> 1);
      est.samples = tte_pkg::SamplesW'(ring_fill);
    end
    return est;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_ms = tte_pkg::GapThresholdReset;
      prev_tap_ms = '0;
      ring_slot = 0;
      ring_fill = 0;
      estimate_q.delete();
      errors_o = 0;
      pending_o = 0;
      results_o = 0;
      restarts_o = 0;
      full_ring_o = 0;
    end else begin
      if (cfg_we_i) gap_limit_ms = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (estimate_q.size() == 0) begin
          $error("estimate transfer with no tap outstanding");
          errors_o++;
        end else begin
          want = estimate_q.pop_front();
          check_field("restarted", want.restarted, restarted_i);
          check_field("average_interval", want.average, average_interval_i);
          check_field("half_spread", want.half_spread, half_spread_i);
          check_field("samples_used", want.samples, samples_used_i);
          if (want.restarted) restarts_o++;
          if (!want.restarted &&
              want.samples == tte_pkg::SamplesW'(tte_pkg::HistoryDepth)) full_ring_o++;
        end
      end
      if (in_valid_i && in_ready_i) estimate_q.push_back(predict_estimate(tap_time_ms_i));
      pending_o = estimate_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the tap_tempo_estimator testbench: clock, reset, tap stimulus, threshold
// writes and handshake idling; tte_checker does prediction and comparison.
// Depends on tte_pkg, tap_tempo_estimator and tte_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 1000000;
  localparam int TailCycles = 40;
  localparam int PhaseTaps  = 250;
  localparam int NumPhases  = 8;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [tte_pkg::ThreshW-1:0]   cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [tte_pkg::TimeW-1:0]     tap_time_ms_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          restarted_o;
  logic [tte_pkg::IntervalW-1:0] average_interval_o;
  logic [tte_pkg::HalfW-1:0]     half_spread_o;
  logic [tte_pkg::SamplesW-1:0]  samples_used_o;

  int errors;
  int pending;
  int results;
  int restarts;
  int full_ring;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;
  int          limit_ms;
  logic [31:0] tap_ms = '0;

  tap_tempo_estimator dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .tap_time_ms_i      (tap_time_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .restarted_o        (restarted_o),
    .average_interval_o (average_interval_o),
    .half_spread_o      (half_spread_o),
    .samples_used_o     (samples_used_o)
  );

  tte_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .tap_time_ms_i      (tap_time_ms_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .restarted_i        (restarted_o),
    .average_interval_i (average_interval_o),
    .half_spread_i      (half_spread_o),
    .samples_used_i     (samples_used_o),
    .errors_o           (errors),
    .pending_o          (pending),
    .results_o          (results),
    .restarts_o         (restarts),
    .full_ring_o        (full_ring)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", CycleLimit);
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid left high so a following tap needs no extra assignment.
  task automatic send_tap(input logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    tap_time_ms_i <= t;
    tap_ms = t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_estimates();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [tte_pkg::ThreshW-1:0] v);
    drain_estimates();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    limit_ms = v;
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 58; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 58; end
      default: begin idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // Mostly bursts of in-range intervals, plus restarts, wild timestamps and wraps.
  task automatic random_taps(input int count);
    int          sent;
    int          kind;
    int          burst;
    int          lo;
    int          hi;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        burst = $urandom_range(1, 25);
        lo = $urandom_range(0, limit_ms);
        hi = ($urandom_range(9) == 0) ? lo : $urandom_range(lo, limit_ms);
        for (int k = 0; k < burst && sent < count; k++) begin
          send_tap(tap_ms + 32'($urandom_range(lo, hi)));
          sent++;
        end
      end else begin
        if (kind < 85) send_tap(tap_ms + 32'(limit_ms) + 32'd1 + 32'($urandom_range(0, 100000)));
        else if (kind < 93) send_tap($urandom());
        else send_tap(tap_ms - 32'($urandom_range(1, 1000)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [tte_pkg::ThreshW-1:0] phase_limit [NumPhases];
    int                          fails;
    phase_limit = '{16'hFFFF, 16'd1, 16'd5000, 16'd0, 16'd300, 16'hFFFF, 16'd40, 16'd5000};
    limit_ms = tte_pkg::GapThresholdReset;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset threshold, first tap against zero, boundary interval, restart
    set_idling(0);
    send_tap(32'd0);
    send_tap(32'd5000);
    send_tap(32'd10001);
    for (int k = 0; k < 11; k++) send_tap(tap_ms + 32'((k * 457 + 1) % 5001));
    // Timestamp wrap: top of range, then past zero by a small step, then backwards
    send_tap(32'hFFFF_FFFF);
    send_tap(32'd3);
    send_tap(32'd2);
    write_threshold(16'hFFFF);
    send_tap(tap_ms + 32'd65535);
    send_tap(tap_ms);
    write_threshold(16'd0);
    send_tap(tap_ms);
    send_tap(tap_ms + 32'd1);
    write_threshold(16'd1);
    send_tap(tap_ms + 32'd1);
    send_tap(tap_ms + 32'd2);

    for (int p = 0; p < NumPhases; p++) begin
      write_threshold(($urandom_range(3) == 0) ? 16'($urandom()) : phase_limit[p]);
      set_idling(p % 4);
      random_taps(PhaseTaps);
    end

    drain_estimates();
    repeat (TailCycles) @(negedge clk_i);
    fails = errors + pending;
    $display("covered %0d taps (%0d restarts, %0d estimates over a full ring)",
             results, restarts, full_ring);
    $display("thresholds from 0 to 65535, with and without idling on either side");
    if (fails == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tte_pkg.sv
hw/rtl/tte_cell.sv
hw/rtl/tte_div.sv
hw/rtl/tap_tempo_estimator.sv
verif/tte_checker.sv
verif/testbench.sv
